// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/tcc_pkg.sv =====
// widths and stage counts for the triangle circumcentre pipeline
`timescale 1ns / 1ps
package tcc_pkg;
    localparam int COORD_W   = 24;
    localparam int OUT_W     = 48;
    localparam int DIF_W     = COORD_W + 1;
    localparam int SQ_W      = 2 * DIF_W;
    localparam int L_W       = SQ_W + 1;
    localparam int D2_W      = L_W + 1;
    localparam int LO_W      = 26;
    localparam int PP_W      = 52;
    localparam int NUM_W     = 80;
    localparam int IN_DATA_W = 6 * COORD_W;
    localparam int OUT_DATA_W = 2 * OUT_W;
    localparam int FRONT     = 6;
    localparam int DIV_LAT   = OUT_W + 2;
    localparam int NST       = FRONT + DIV_LAT;
endpackage

// ===== hdl/tcc_div.sv =====
// pipelined restoring divider with truncation and output saturation
`timescale 1ns / 1ps
module tcc_div (
    input  logic                                i_clk,
    input  logic                                i_ce,
    input  logic signed [tcc_pkg::NUM_W-1:0]    i_num,
    input  logic signed [tcc_pkg::D2_W-1:0]     i_den,
    output logic signed [tcc_pkg::OUT_W-1:0]    o_val,
    output logic                                o_ovf
);
    import tcc_pkg::*;

    logic [NUM_W-1:0] r_an;
    logic [D2_W-1:0]  r_ad;
    logic             r_sg;
    logic [D2_W-1:0]  r_rem [0:OUT_W];
    logic [OUT_W-1:0] r_low [0:OUT_W];
    logic [OUT_W-1:0] r_q   [0:OUT_W];
    logic [D2_W-1:0]  r_d   [0:OUT_W];
    logic             r_neg [0:OUT_W];
    logic             r_ovr [0:OUT_W];
    logic [OUT_W-1:0] w_q;
    logic [NUM_W-OUT_W-1:0] w_hi;

    assign w_hi = r_an[NUM_W-1:OUT_W];

    // magnitudes and quotient sign
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_an <= i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
            r_ad <= i_den[D2_W-1] ? D2_W'(-i_den) : D2_W'(i_den);
            r_sg <= i_num[NUM_W-1] ^ i_den[D2_W-1];
        end
    end

    // quotient too wide for the output when the top part already reaches the divisor
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_ovr[0] <= D2_W'(w_hi) >= r_ad;
            r_rem[0] <= D2_W'(w_hi);
            r_low[0] <= r_an[OUT_W-1:0];
            r_q[0]   <= '0;
            r_d[0]   <= r_ad;
            r_neg[0] <= r_sg;
        end
    end

    // one quotient bit per stage
    for (genvar j = 0; j < OUT_W; j++) begin : g_step
        logic [D2_W:0] w_sh;
        logic [D2_W:0] w_tr;
        assign w_sh = {r_rem[j], r_low[j][OUT_W-1]};
        assign w_tr = w_sh - {1'b0, r_d[j]};
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[j+1] <= w_tr[D2_W] ? w_sh[D2_W-1:0] : w_tr[D2_W-1:0];
                r_low[j+1] <= r_low[j] << 1;
                r_q[j+1]   <= {r_q[j][OUT_W-2:0], ~w_tr[D2_W]};
                r_d[j+1]   <= r_d[j];
                r_neg[j+1] <= r_neg[j];
                r_ovr[j+1] <= r_ovr[j];
            end
        end
    end

    // sign and clamp to the output range
    assign w_q = r_q[OUT_W];
    always_comb begin
        o_ovf = 1'b0;
        o_val = $signed(w_q);
        if (!r_neg[OUT_W]) begin
            if (r_ovr[OUT_W] || w_q[OUT_W-1]) begin
                o_ovf = 1'b1;
                o_val = $signed({1'b0, {(OUT_W-1){1'b1}}});
            end
        end else begin
            if (r_ovr[OUT_W] || (w_q[OUT_W-1] && (|w_q[OUT_W-2:0]))) begin
                o_ovf = 1'b1;
                o_val = $signed({1'b1, {(OUT_W-1){1'b0}}});
            end else begin
                o_val = -$signed(w_q);
            end
        end
    end
endmodule

// ===== hdl/triangle_circumcenter.sv =====
// Circumcentre of a 2D triangle: takes one triangle (three Q8.16 vertices) per clock
// cycle while the output is not stalled and returns the Q32.16 centre, truncated toward
// zero. Each beat passes 57 register stages: the 6-stage arithmetic front end (differences,
// squares, determinant, split wide products, recombination, numerators), the 50-stage
// divider (magnitudes, range check, then 48 restoring stages, one quotient bit each) and
// the output register.
// Collinear vertices give zero coordinates with degenerate set; a centre outside the
// Q32.16 range is clamped and flags overflowed. A stall freezes the whole pipeline.
`timescale 1ns / 1ps
module triangle_circumcenter (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // ax, ay, bx, by, cx, cy
    input  logic [tcc_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // center_x, center_y
    output logic [tcc_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // degenerate, overflowed
    output logic [1:0]                           m_axis_tuser
);
    import tcc_pkg::*;

    logic w_ce;
    logic signed [COORD_W-1:0] w_ax, w_ay, w_bx, w_by, w_cx, w_cy;

    logic signed [DIF_W-1:0]   r_u1, r_v1, r_s1, r_t1, r_u2, r_v2, r_s2, r_t2;
    logic signed [DIF_W-1:0]   r_u3, r_v3, r_s3, r_t3;
    logic signed [COORD_W-1:0] r_ax1, r_ay1, r_ax2, r_ay2, r_ax3, r_ay3;
    logic signed [SQ_W-1:0]    r_uu, r_vv, r_ss, r_tt, r_ut, r_sv;
    logic signed [L_W-1:0]     r_det, r_l1, r_l2;
    logic signed [D2_W-1:0]    w_d2, r_d2_4, r_d2_5, r_d2_6;
    logic signed [LO_W:0]      w_l1_lo, w_l2_lo, w_d2_lo;
    logic signed [L_W-LO_W-1:0] w_l1_hi, w_l2_hi;
    logic signed [D2_W-LO_W-1:0] w_d2_hi;
    logic signed [PP_W-1:0]    r_tl1_lo, r_tl1_hi, r_vl2_lo, r_vl2_hi;
    logic signed [PP_W-1:0]    r_ul2_lo, r_ul2_hi, r_sl1_lo, r_sl1_hi;
    logic signed [PP_W-1:0]    r_dax_lo, r_dax_hi, r_day_lo, r_day_hi;
    logic signed [NUM_W-1:0]   r_tl1, r_vl2, r_ul2, r_sl1, r_dax, r_day, r_nx, r_ny;
    logic                      r_deg4, r_deg5, r_deg6;
    logic                      r_dg  [0:DIV_LAT-1];
    logic                      r_vld [0:NST-1];
    logic signed [OUT_W-1:0]   w_qx, w_qy, r_cx, r_cy;
    logic                      w_ox, w_oy, r_ovld, r_odeg, r_oovf;

    // whole pipeline advances unless the output beat is held
    assign w_ce = !r_ovld || m_axis_tready;
    assign s_axis_tready = w_ce;

    assign w_ax = s_axis_tdata[0*COORD_W +: COORD_W];
    assign w_ay = s_axis_tdata[1*COORD_W +: COORD_W];
    assign w_bx = s_axis_tdata[2*COORD_W +: COORD_W];
    assign w_by = s_axis_tdata[3*COORD_W +: COORD_W];
    assign w_cx = s_axis_tdata[4*COORD_W +: COORD_W];
    assign w_cy = s_axis_tdata[5*COORD_W +: COORD_W];

    // split operands for narrow partial products
    assign w_d2    = $signed({r_det, 1'b0});
    assign w_l1_lo = $signed({1'b0, r_l1[LO_W-1:0]});
    assign w_l2_lo = $signed({1'b0, r_l2[LO_W-1:0]});
    assign w_d2_lo = $signed({1'b0, w_d2[LO_W-1:0]});
    assign w_l1_hi = $signed(r_l1[L_W-1:LO_W]);
    assign w_l2_hi = $signed(r_l2[L_W-1:LO_W]);
    assign w_d2_hi = $signed(w_d2[D2_W-1:LO_W]);

    // arithmetic front end
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            // edge vectors from the first vertex
            r_u1  <= DIF_W'(w_bx) - DIF_W'(w_ax);
            r_v1  <= DIF_W'(w_by) - DIF_W'(w_ay);
            r_s1  <= DIF_W'(w_cx) - DIF_W'(w_ax);
            r_t1  <= DIF_W'(w_cy) - DIF_W'(w_ay);
            r_ax1 <= w_ax;
            r_ay1 <= w_ay;
            // squares and cross terms
            r_uu <= r_u1 * r_u1;
            r_vv <= r_v1 * r_v1;
            r_ss <= r_s1 * r_s1;
            r_tt <= r_t1 * r_t1;
            r_ut <= r_u1 * r_t1;
            r_sv <= r_s1 * r_v1;
            r_u2 <= r_u1; r_v2 <= r_v1; r_s2 <= r_s1; r_t2 <= r_t1;
            r_ax2 <= r_ax1; r_ay2 <= r_ay1;
            // determinant and squared edge lengths
            r_det <= L_W'(r_ut) - L_W'(r_sv);
            r_l1  <= L_W'(r_uu) + L_W'(r_vv);
            r_l2  <= L_W'(r_ss) + L_W'(r_tt);
            r_u3 <= r_u2; r_v3 <= r_v2; r_s3 <= r_s2; r_t3 <= r_t2;
            r_ax3 <= r_ax2; r_ay3 <= r_ay2;
            // partial products of the numerator terms
            r_tl1_lo <= r_t3 * w_l1_lo;
            r_tl1_hi <= r_t3 * w_l1_hi;
            r_vl2_lo <= r_v3 * w_l2_lo;
            r_vl2_hi <= r_v3 * w_l2_hi;
            r_ul2_lo <= r_u3 * w_l2_lo;
            r_ul2_hi <= r_u3 * w_l2_hi;
            r_sl1_lo <= r_s3 * w_l1_lo;
            r_sl1_hi <= r_s3 * w_l1_hi;
            r_dax_lo <= r_ax3 * w_d2_lo;
            r_dax_hi <= r_ax3 * w_d2_hi;
            r_day_lo <= r_ay3 * w_d2_lo;
            r_day_hi <= r_ay3 * w_d2_hi;
            r_d2_4   <= w_d2;
            r_deg4   <= (r_det == '0);
            // recombine partial products
            r_tl1 <= (NUM_W'(r_tl1_hi) <<< LO_W) + NUM_W'(r_tl1_lo);
            r_vl2 <= (NUM_W'(r_vl2_hi) <<< LO_W) + NUM_W'(r_vl2_lo);
            r_ul2 <= (NUM_W'(r_ul2_hi) <<< LO_W) + NUM_W'(r_ul2_lo);
            r_sl1 <= (NUM_W'(r_sl1_hi) <<< LO_W) + NUM_W'(r_sl1_lo);
            r_dax <= (NUM_W'(r_dax_hi) <<< LO_W) + NUM_W'(r_dax_lo);
            r_day <= (NUM_W'(r_day_hi) <<< LO_W) + NUM_W'(r_day_lo);
            r_d2_5 <= r_d2_4;
            r_deg5 <= r_deg4;
            // cubic numerators
            r_nx   <= r_dax + r_tl1 - r_vl2;
            r_ny   <= r_day + r_ul2 - r_sl1;
            r_d2_6 <= r_d2_5;
            r_deg6 <= r_deg5;
        end
    end

    tcc_div u_div_x (
        .i_clk (i_clk),
        .i_ce  (w_ce),
        .i_num (r_nx),
        .i_den (r_d2_6),
        .o_val (w_qx),
        .o_ovf (w_ox)
    );

    tcc_div u_div_y (
        .i_clk (i_clk),
        .i_ce  (w_ce),
        .i_num (r_ny),
        .i_den (r_d2_6),
        .o_val (w_qy),
        .o_ovf (w_oy)
    );

    // degenerate flag follows the divider
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_dg[0] <= r_deg6;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_dg[k] <= r_dg[k-1];
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_ovld <= 1'b0;
        end else if (w_ce) begin
            r_vld[0] <= s_axis_tvalid;
            for (int k = 1; k < NST; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_ovld <= r_vld[NST-1];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_odeg <= r_dg[DIV_LAT-1];
            r_cx   <= r_dg[DIV_LAT-1] ? '0 : w_qx;
            r_cy   <= r_dg[DIV_LAT-1] ? '0 : w_qy;
            r_oovf <= !r_dg[DIV_LAT-1] && (w_ox || w_oy);
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {r_cy, r_cx};
    assign m_axis_tuser  = {r_oovf, r_odeg};
endmodule

// ===== hdl/tcc_check.sv =====
// port-level checks for the circumcentre block, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tcc_check (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [tcc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic [1:0]                      m_axis_tuser
);
    import tcc_pkg::*;

    logic w_deg, w_ovf, w_satx, w_saty;
    logic [OUT_W-1:0] w_x, w_y;

    assign w_deg  = m_axis_tuser[0];
    assign w_ovf  = m_axis_tuser[1];
    assign w_x    = m_axis_tdata[OUT_W-1:0];
    assign w_y    = m_axis_tdata[2*OUT_W-1:OUT_W];
    assign w_satx = (w_x == {1'b0, {(OUT_W-1){1'b1}}}) || (w_x == {1'b1, {(OUT_W-1){1'b0}}});
    assign w_saty = (w_y == {1'b0, {(OUT_W-1){1'b1}}}) || (w_y == {1'b1, {(OUT_W-1){1'b0}}});

    // collinear result carries zero centre and no overflow
    `ASSERT_IMPL(a_deg_zero, i_clk, i_rst_n, m_axis_tvalid && w_deg, (w_x == '0) && (w_y == '0) && !w_ovf)
    // overflow only with a clamped coordinate
    `ASSERT_IMPL(a_ovf_sat, i_clk, i_rst_n, m_axis_tvalid && w_ovf, w_satx || w_saty)
    // held output beat stays
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    // input is taken whenever the output side is free
    `ASSERT_IMPL(a_ready_free, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready)
endmodule

bind triangle_circumcenter tcc_check u_tcc_check (.*);
